FILE: design/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the HTTP response head parser
// Byte kinds, error codes, parse state and queue entry layout.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [3:0] PREFIX_LEN = 4'd9;
  localparam logic [3:0] LEN_SAT    = 4'd10;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [3:0] ALT_POS    = 4'd7;

  typedef enum logic [3:0] {
    K_CODE       = 4'd0,
    K_REASON     = 4'd1,
    K_NAME       = 4'd2,
    K_VALUE      = 4'd3,
    K_BODY       = 4'd4,
    K_STATUS_END = 4'd5,
    K_HEADER_END = 4'd6,
    K_HEAD_END   = 4'd7,
    K_ERROR      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_PREFIX   = 3'd2,
    ERR_NO_CODE  = 3'd3,
    ERR_NO_COLON = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    MODE_STATUS  = 2'd0,
    MODE_HEADERS = 2'd1,
    MODE_BODY    = 2'd2,
    MODE_HALTED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PART_NAME  = 2'd0,
    PART_SKIP  = 2'd1,
    PART_VALUE = 2'd2
  } part_e;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] len;
    logic       pok;
    logic       sp;
    part_e      part;
  } pstate_t;

  localparam pstate_t PSTATE_RESET = '{
    mode: MODE_STATUS, len: 4'd0, pok: 1'b1, sp: 1'b0, part: PART_NAME
  };

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       err;
  } res_t;

  typedef struct packed {
    pstate_t st;
    logic    hit;
    res_t    res;
  } step_t;

  // one queue entry holds every result of one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // expected status line prefix; position 7 also accepts '0'
  function automatic logic [7:0] prefix_char(logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: design/hrhp_if.sv
// ----------------------------------------------------------------------------
// hrhp_if: stream channels of the HTTP response head parser
// Input byte channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_response;

  modport source (output valid, output in_byte, output start_of_response, input ready);
  modport sink   (input valid, input in_byte, input start_of_response, output ready);
endinterface

interface hrhp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

FILE: design/hrhp_front.sv
// ----------------------------------------------------------------------------
// hrhp_front: byte classifier of the HTTP response head parser
// Holds the parse state, tags each accepted byte and queues its results.
// ----------------------------------------------------------------------------
module hrhp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  hrhp_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output hrhp_pkg::entry_t entry_o
);
  import hrhp_pkg::*;

  pstate_t st_q, st_d;
  logic    cr_q, cr_d;

  function automatic step_t content_step(pstate_t s, logic [7:0] b);
    step_t t;
    t.st           = s;
    t.hit          = 1'b0;
    t.res.out_byte = b;
    t.res.kind     = K_CODE;
    t.res.err      = ERR_NONE;
    if (s.mode == MODE_STATUS) begin
      if (s.len < PREFIX_LEN) begin
        if (!((b == prefix_char(s.len)) || (s.len == ALT_POS && b == CH_ZERO))) begin
          t.st.pok = 1'b0;
        end
      end else if (!s.sp) begin
        if (b == CH_SPACE) t.st.sp = 1'b1;
        else               t.hit   = 1'b1;
      end else begin
        t.hit      = 1'b1;
        t.res.kind = K_REASON;
      end
    end else begin
      if (s.part == PART_NAME) begin
        if (b == CH_COLON) t.st.part = PART_SKIP;
        else begin
          t.hit      = 1'b1;
          t.res.kind = K_NAME;
        end
      end else if (s.part == PART_SKIP) begin
        if (b != CH_SPACE) begin
          t.st.part  = PART_VALUE;
          t.hit      = 1'b1;
          t.res.kind = K_VALUE;
        end
      end else begin
        t.hit      = 1'b1;
        t.res.kind = K_VALUE;
      end
    end
    if (s.len < LEN_SAT) t.st.len = s.len + 4'd1;
    return t;
  endfunction

  function automatic step_t line_end(pstate_t s);
    step_t t;
    t.st           = s;
    t.hit          = 1'b1;
    t.res.out_byte = 8'h00;
    t.res.kind     = K_ERROR;
    t.res.err      = ERR_NONE;
    if (s.mode == MODE_STATUS) begin
      if (s.len < PREFIX_LEN) t.res.err = ERR_SHORT;
      else if (!s.pok)        t.res.err = ERR_PREFIX;
      else if (!s.sp)         t.res.err = ERR_NO_CODE;
      if (t.res.err != ERR_NONE) begin
        t.st.mode = MODE_HALTED;
      end else begin
        t.res.kind = K_STATUS_END;
        t.st.mode  = MODE_HEADERS;
      end
    end else begin
      if (s.len == 4'd0) begin
        t.res.kind = K_HEAD_END;
        t.st.mode  = MODE_BODY;
      end else if (s.part == PART_NAME) begin
        t.res.err = ERR_NO_COLON;
        t.st.mode = MODE_HALTED;
      end else begin
        t.res.kind = K_HEADER_END;
      end
    end
    t.st.len  = 4'd0;
    t.st.part = PART_NAME;
    return t;
  endfunction

  logic    accept;
  pstate_t st_s;
  logic    cr_s;
  step_t   p0, p1;
  logic    done;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    st_s = st_q;
    cr_s = cr_q;
    if (in_i.start_of_response) begin
      st_s = PSTATE_RESET;
      cr_s = 1'b0;
    end
    p0      = '0;
    p0.st   = st_s;
    p1      = '0;
    p1.st   = st_s;
    done    = 1'b0;
    cr_d    = cr_s;
    unique case (st_s.mode)
      MODE_HALTED: begin
        // drop everything until a new response
      end
      MODE_BODY: begin
        p1.hit          = 1'b1;
        p1.res.out_byte = in_i.in_byte;
        p1.res.kind     = K_BODY;
        p1.res.err      = ERR_NONE;
      end
      default: begin
        if (cr_s) begin
          cr_d = 1'b0;
          if (in_i.in_byte == CH_LF) begin
            p0   = line_end(st_s);
            done = 1'b1;
          end else begin
            p0 = content_step(st_s, CH_CR);
          end
        end
        p1.st = p0.st;
        if (!done) begin
          if (in_i.in_byte == CH_CR) cr_d = 1'b1;
          else                       p1   = content_step(p0.st, in_i.in_byte);
        end
      end
    endcase
    st_d = p1.st;
  end

  always_comb begin
    push_o    = accept && (p0.hit || p1.hit);
    entry_o.two = p0.hit && p1.hit;
    entry_o.r0  = p0.hit ? p0.res : p1.res;
    entry_o.r1  = p1.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PSTATE_RESET;
      cr_q <= 1'b0;
    end else if (accept) begin
      st_q <= st_d;
      cr_q <= cr_d;
    end
  end

endmodule

FILE: design/hrhp_queue.sv
// ----------------------------------------------------------------------------
// hrhp_queue: result queue between classifier and emitter
// Small register FIFO of per-byte result entries, head read directly.
// ----------------------------------------------------------------------------
module hrhp_queue #(
  parameter int unsigned Depth = hrhp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hrhp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output hrhp_pkg::entry_t head_o
);
  import hrhp_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  entry_t           mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
      if (do_pop)  rd_q <= (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: design/hrhp_back.sv
// ----------------------------------------------------------------------------
// hrhp_back: result emitter of the HTTP response head parser
// Unrolls queued entries into single result beats in an output register.
// ----------------------------------------------------------------------------
module hrhp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  hrhp_pkg::entry_t head_i,
  output logic             pop_o,
  hrhp_out_if.source       out_o
);
  import hrhp_pkg::*;

  logic idx_q, idx_d;
  logic valid_q, valid_d;
  res_t data_q, data_d;
  logic last_q, last_d;
  logic load, fin;

  always_comb begin
    load    = !valid_q || out_o.ready;
    fin     = !head_i.two || idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        data_d = idx_q ? head_i.r1 : head_i.r0;
        last_d = fin;
        pop_o  = fin;
        idx_d  = !fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = data_q.out_byte;
  assign out_o.kind       = data_q.kind;
  assign out_o.error_code = data_q.err;
  assign out_o.last       = last_q;

endmodule

FILE: design/http_response_head_parser_core.sv
// ----------------------------------------------------------------------------
// http_response_head_parser_core: HTTP/1.x response head parser
// Tags response bytes as code, reason, header name/value or body and emits
// line and section markers plus a one-shot error marker.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | beat
//  ---------+-----+----------------------------------------+---------------------
//  in_i     | in  | in_byte[7:0], start_of_response        | one response byte
//  out_o    | out | out_byte[7:0], kind[3:0],              | one result; last on
//           |     | error_code[2:0], last                  | final of its byte
//
//  Flow: one input byte is taken per clock while the queue is not full; each
//  byte yields zero, one or two result beats, and the emitter sends one beat
//  per clock while out_o is not stalled.
//  Path: the results of a byte enter the queue when the byte is taken, then
//  reach the output register when the emitter loads them.
//  Reset: rst_ni clears the parse state, the queue pointers and output valid.
//  Stalls: the queue decouples the sides; input stalls only when it is full.
// ----------------------------------------------------------------------------
module http_response_head_parser_core #(
  parameter int unsigned QueueDepth = hrhp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source out_o
);
  import hrhp_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t push_entry;
  entry_t head;

  // classify each accepted byte and queue its results
  hrhp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (push_entry)
  );

  // hold per-byte result entries between the two sides
  hrhp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // advance one result beat per clock into the output register while out_o is not stalled
  hrhp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

FILE: design/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker: port-level checks of the HTTP response head parser
// Output hold under stall and consistency of result markers.
// ----------------------------------------------------------------------------
module hrhp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [3:0] kind_i,
  input logic [2:0] error_code_i,
  input logic       last_i
);
  import hrhp_pkg::*;

  // hold a stalled beat unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(kind_i) && $stable(error_code_i) && $stable(last_i))
    else $error("stalled result beat changed");

  // error code is set exactly on error markers
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == K_ERROR) == (error_code_i != ERR_NONE)))
    else $error("error code does not match kind");

  // markers carry no byte and always close their input byte
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i >= K_STATUS_END) |-> last_i && (out_byte_i == 8'h00))
    else $error("marker beat malformed");

  // second result of a byte follows right after the first is taken
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("second result of a byte missing");

endmodule

bind http_response_head_parser_core hrhp_checker u_hrhp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .kind_i       (out_o.kind),
  .error_code_i (out_o.error_code),
  .last_i       (out_o.last)
);

FILE: bench/http_response_head_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_response_head_parser_core_test: self-checking bench of the head parser
// Streams HTTP/1.x response bytes into the parser, predicts every result beat
// with an in-bench parser model and compares each beat field by field. A short
// table of directed bytes comes first, then randomly shaped responses.
// ----------------------------------------------------------------------------
module http_response_head_parser_core_test;
  import hrhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [71:0] VERSION_TEXT = "HTTP/1.1 ";

  // How a stimulus row gets its expectation: from the model, or typed in.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
    logic       last;
  } parsed_beat_t;

  typedef struct packed {
    logic [7:0]   in_byte;
    logic         sor;
    row_check_e   chk;
    parsed_beat_t typed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrhp_in_if  in_ch ();
  hrhp_out_if out_ch ();

  http_response_head_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state, advanced once per accepted byte.
  // --------------------------------------------------------------------------
  mode_e      pm_mode;
  logic       pm_cr_held;
  logic [3:0] pm_line_len;
  logic       pm_prefix_ok;
  logic       pm_space_seen;
  part_e      pm_part;

  parsed_beat_t byte_beats[$];      // beats caused by the byte just parsed
  parsed_beat_t expected_beats[$];  // beats still owed by the parser
  stim_row_t    directed_rows[$];
  logic [7:0]   resp_text[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          send_burst = 0;
  int          recv_burst = 0;

  function automatic logic [7:0] version_char(logic [3:0] pos);
    return VERSION_TEXT[8*(8-pos) +: 8];
  endfunction

  function automatic void model_reset();
    pm_mode       = MODE_STATUS;
    pm_cr_held    = 1'b0;
    pm_line_len   = 4'd0;
    pm_prefix_ok  = 1'b1;
    pm_space_seen = 1'b0;
    pm_part       = PART_NAME;
  endfunction

  function automatic void add_beat(logic [7:0] d, kind_e k, err_e e);
    byte_beats.push_back('{data: d, kind: k, err: e, last: 1'b0});
  endfunction

  // Content byte of the current line: prefix compare, code, reason, name, value.
  function automatic void model_content(logic [7:0] b);
    if (pm_mode == MODE_STATUS) begin
      if (pm_line_len < PREFIX_LEN) begin
        if (!(b == version_char(pm_line_len) || (pm_line_len == ALT_POS && b == CH_ZERO)))
          pm_prefix_ok = 1'b0;
      end else if (!pm_space_seen) begin
        if (b == CH_SPACE) pm_space_seen = 1'b1;
        else add_beat(b, K_CODE, ERR_NONE);
      end else begin
        add_beat(b, K_REASON, ERR_NONE);
      end
    end else begin
      case (pm_part)
        PART_NAME: begin
          if (b == CH_COLON) pm_part = PART_SKIP;
          else add_beat(b, K_NAME, ERR_NONE);
        end
        PART_SKIP: begin
          if (b != CH_SPACE) begin
            pm_part = PART_VALUE;
            add_beat(b, K_VALUE, ERR_NONE);
          end
        end
        default: add_beat(b, K_VALUE, ERR_NONE);
      endcase
    end
    if (pm_line_len < LEN_SAT) pm_line_len++;
  endfunction

  // CR LF seen: close the status line or a header line.
  function automatic void model_line_end();
    err_e e;
    e = ERR_NONE;
    if (pm_mode == MODE_STATUS) begin
      if (pm_line_len < PREFIX_LEN) e = ERR_SHORT;
      else if (!pm_prefix_ok) e = ERR_PREFIX;
      else if (!pm_space_seen) e = ERR_NO_CODE;
      if (e != ERR_NONE) begin
        add_beat(8'h00, K_ERROR, e);
        pm_mode = MODE_HALTED;
      end else begin
        add_beat(8'h00, K_STATUS_END, ERR_NONE);
        pm_mode = MODE_HEADERS;
      end
    end else if (pm_line_len == 4'd0) begin
      add_beat(8'h00, K_HEAD_END, ERR_NONE);
      pm_mode = MODE_BODY;
    end else if (pm_part == PART_NAME) begin
      add_beat(8'h00, K_ERROR, ERR_NO_COLON);
      pm_mode = MODE_HALTED;
    end else begin
      add_beat(8'h00, K_HEADER_END, ERR_NONE);
    end
    pm_line_len = 4'd0;
    pm_part     = PART_NAME;
  endfunction

  // Parse one byte; fills byte_beats and returns 1 when the byte is ignored.
  function automatic logic model_parse(logic [7:0] b, logic sor);
    logic line_done;
    line_done = 1'b0;
    byte_beats.delete();
    if (sor) model_reset();
    if (pm_mode == MODE_HALTED) return 1'b1;
    if (pm_mode == MODE_BODY) begin
      add_beat(b, K_BODY, ERR_NONE);
    end else begin
      // a held CR either closes the line or goes out as content
      if (pm_cr_held) begin
        pm_cr_held = 1'b0;
        if (b == CH_LF) begin
          model_line_end();
          line_done = 1'b1;
        end else begin
          model_content(CH_CR);
        end
      end
      if (!line_done) begin
        if (b == CH_CR) pm_cr_held = 1'b1;
        else model_content(b);
      end
    end
    if (byte_beats.size() > 0) byte_beats[byte_beats.size()-1].last = 1'b1;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Idle draws: a random idle gap, or none during an occasional run of back-to-back beats.
  // --------------------------------------------------------------------------
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] pick_text();
    case ($urandom_range(0, 15))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_COLON;
      3:       return CH_SPACE;
      4:       return 8'($urandom);
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic void add_row(logic [7:0] b, logic sor, row_check_e chk,
                                  logic [7:0] d, kind_e k, err_e e);
    directed_rows.push_back('{in_byte: b, sor: sor, chk: chk,
                              typed: '{data: d, kind: k, err: e, last: 1'b1}});
  endfunction

  // Drive one byte, hold it until taken, then record what it owes.
  task automatic send_byte(input logic [7:0] b, input logic sor, input row_check_e chk,
                           input parsed_beat_t typed, output logic ignored);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.in_byte           <= b;
    in_ch.start_of_response <= sor;
    do @(posedge clk_i); while (!in_ch.ready);
    ignored = model_parse(b, sor);
    case (chk)
      CHK_MODEL: foreach (byte_beats[i]) expected_beats.push_back(byte_beats[i]);
      CHK_ONE:   expected_beats.push_back(typed);
      default:   ;
    endcase
  endtask

  // Hold the input off until every owed beat has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  // One response: status line, headers, empty line and body, now and then
  // broken, cut short or replaced by noise.
  task automatic build_response(output logic sor_first);
    int         bad_pos;
    int         n_hdr;
    logic [7:0] c;
    resp_text.delete();
    sor_first = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      sor_first = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 20))
        resp_text.push_back($urandom_range(0, 1) ? pick_text() : 8'($urandom));
      return;
    end
    if ($urandom_range(0, 11) == 0) begin
      for (int p = 0; p < $urandom_range(0, 8); p++)
        resp_text.push_back(version_char(4'(p)));
    end else begin
      bad_pos = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 8) : 15;
      for (int p = 0; p < 9; p++) begin
        c = version_char(4'(p));
        if (p == ALT_POS && $urandom_range(0, 1)) c = CH_ZERO;
        if (p == bad_pos) c = 8'($urandom);
        resp_text.push_back(c);
      end
      if ($urandom_range(0, 11) == 0) begin
        // digits with no separator: the code never ends
        repeat ($urandom_range(1, 3)) resp_text.push_back(8'(48 + $urandom_range(0, 9)));
      end else begin
        repeat ($urandom_range(0, 3)) resp_text.push_back(8'(48 + $urandom_range(0, 9)));
        resp_text.push_back(CH_SPACE);
      end
      repeat ($urandom_range(0, 6)) resp_text.push_back(pick_text());
    end
    resp_text.push_back(CH_CR);
    resp_text.push_back(CH_LF);
    n_hdr = $urandom_range(0, 3);
    for (int h = 0; h < n_hdr; h++) begin
      repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5))
        resp_text.push_back(8'($urandom_range(65, 122)));
      if ($urandom_range(0, 11) != 0) resp_text.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) resp_text.push_back(CH_SPACE);
      repeat ($urandom_range(0, 6)) resp_text.push_back(pick_text());
      resp_text.push_back(CH_CR);
      resp_text.push_back(CH_LF);
    end
    resp_text.push_back(CH_CR);
    resp_text.push_back(CH_LF);
    repeat ($urandom_range(0, 6)) resp_text.push_back(8'($urandom));
    // cut the tail off now and then; the next start discards what is left
    if ($urandom_range(0, 7) == 0)
      while (resp_text.size() > 1 && $urandom_range(0, 3) != 0) void'(resp_text.pop_back());
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, compare each beat with the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    int           stall;
    parsed_beat_t want;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(recv_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %0h kind %0d error_code %0d",
               out_ch.out_byte, out_ch.kind, out_ch.error_code);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", 32'(want.data), 32'(out_ch.out_byte));
        check_field("kind", 32'(want.kind), 32'(out_ch.kind));
        check_field("error_code", 32'(want.err), 32'(out_ch.error_code));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("http_response_head_parser_core_test: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random responses.
  // --------------------------------------------------------------------------
  initial begin
    parsed_beat_t no_beat;
    logic         ignored;
    logic         sor_first;
    int unsigned  counted;
    int unsigned  resp_no;
    no_beat   = '0;
    counted   = 0;
    resp_no   = 0;
    rst_ni    = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.in_byte           = 8'h00;
    in_ch.start_of_response = 1'b0;
    model_reset();

    // status line that is too short, then a byte dropped while halted
    add_row("H",   1'b1, CHK_NONE, 8'h00, K_CODE, ERR_NONE);
    add_row(CH_CR, 1'b0, CHK_NONE, 8'h00, K_CODE, ERR_NONE);
    add_row(CH_LF, 1'b0, CHK_ONE,  8'h00, K_ERROR, ERR_SHORT);
    add_row(8'hFF, 1'b0, CHK_NONE, 8'h00, K_CODE, ERR_NONE);
    // version prefix with the alternate minor digit: no beats
    for (int p = 0; p < 9; p++)
      add_row((p == ALT_POS) ? CH_ZERO : version_char(4'(p)), p == 0, CHK_NONE,
              8'h00, K_CODE, ERR_NONE);
    add_row("7",      1'b0, CHK_MODEL, 8'h00, K_CODE, ERR_NONE);
    add_row(CH_SPACE, 1'b0, CHK_NONE,  8'h00, K_CODE, ERR_NONE);
    add_row(8'h00,    1'b0, CHK_ONE,   8'h00, K_REASON, ERR_NONE);
    // CR then CR: the first goes out as reason content, the second is held
    add_row(CH_CR,    1'b0, CHK_NONE,  8'h00, K_CODE, ERR_NONE);
    add_row(CH_CR,    1'b0, CHK_ONE,   CH_CR, K_REASON, ERR_NONE);
    add_row(CH_LF,    1'b0, CHK_ONE,   8'h00, K_STATUS_END, ERR_NONE);
    // header with an empty name and a lone LF as its value
    add_row(CH_COLON, 1'b0, CHK_NONE,  8'h00, K_CODE, ERR_NONE);
    add_row(CH_LF,    1'b0, CHK_MODEL, 8'h00, K_CODE, ERR_NONE);
    add_row(CH_CR,    1'b0, CHK_NONE,  8'h00, K_CODE, ERR_NONE);
    add_row(CH_LF,    1'b0, CHK_ONE,   8'h00, K_HEADER_END, ERR_NONE);
    add_row(CH_CR,    1'b0, CHK_NONE,  8'h00, K_CODE, ERR_NONE);
    add_row(CH_LF,    1'b0, CHK_ONE,   8'h00, K_HEAD_END, ERR_NONE);
    add_row(CH_CR,    1'b0, CHK_MODEL, 8'h00, K_CODE, ERR_NONE);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].in_byte, directed_rows[i].sor, directed_rows[i].chk,
                directed_rows[i].typed, ignored);
    drain_results();

    while (counted < RANDOM_ITEMS) begin
      build_response(sor_first);
      foreach (resp_text[i]) begin
        send_byte(resp_text[i], (i == 0) ? sor_first : 1'b0, CHK_MODEL, no_beat, ignored);
        if (!ignored) counted++;
      end
      resp_no++;
      // let the result side empty out every few responses
      if (resp_no % 7 == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("http_response_head_parser_core_test: clean");
    end else begin
      $display("http_response_head_parser_core_test: errors");
    end
    $finish;
  end

endmodule
